// ===== src/dds_pkg.sv =====
// Package for the decimal digit-by-digit square root pipeline.
// Holds widths, constants and the single digit-step function. No dependencies.
package dds_pkg;

	localparam int RADICAND_W    = 14;
	localparam int ROOT_W        = 57;
	localparam int REM_W         = 66;
	localparam int PAIR_W        = 7;
	localparam int INT_PAIRS     = 3;
	localparam int RADICAND_LIMIT = 10000;
	localparam int PAIR_BASE     = 100;
	// x / 100 == (x * 5243) >> 19 for x below 10000
	localparam int DIV100_MUL    = 5243;
	localparam int DIV100_SHIFT  = 19;
	localparam int DIV100_PROD_W = 27;

	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [PAIR_W-1:0] pair_t;

	typedef struct packed {
		rem_t  rem;
		root_t q;
	} step_t;

	// one decimal digit: bring down pair, pick largest d with (20q+d)d <= rem
	function automatic step_t digit_step(rem_t rem, root_t q, pair_t pair);
		rem_t              cur;
		rem_t              q20;
		rem_t              trial;
		rem_t              take;
		logic [3:0]        d;
		logic [ROOT_W+3:0] qn;
		step_t             r;
		cur  = (rem << 6) + (rem << 5) + (rem << 2) + REM_W'(pair);
		q20  = (REM_W'(q) << 4) + (REM_W'(q) << 2);
		d    = 4'd0;
		take = '0;
		for (int t = 1; t <= 9; t++) begin
			trial = (q20 + REM_W'(t)) * REM_W'(t);
			if (trial <= cur) begin
				d    = 4'(t);
				take = trial;
			end
		end
		qn = ({4'b0, q} << 3) + ({4'b0, q} << 1) + (ROOT_W+4)'(d);
		r.rem = cur - take;
		r.q   = qn[ROOT_W-1:0];
		return r;
	endfunction

endpackage

// ===== src/decimal_digit_square_root.sv =====
// Top level of the decimal digit-by-digit square root.
// Depends on dds_pkg; one pipeline stage per root digit.
//
// Usage: raise start with a radicand; it is taken at any edge where busy is
// low, and busy never rises, so one radicand may enter every cycle.
// The root, floor(sqrt(radicand) * 10^FRACTION_DIGITS), appears on
// scaled_root with out_of_range, marked by a one-cycle done strobe.
// Radicands above 10000 give out_of_range = 1 and a zero root.
// From the start transfer to done the radicand passes one input register,
// then one register stage per digit (3 + FRACTION_DIGITS digits).
// Throughput: one transfer per cycle; each digit stage holds one
// trial-divisor compare bank.
// Reset clears all valid bits; nothing in flight survives it.
// The receiver cannot stall: each result is shown for exactly one cycle and
// must be captured when done is high.
//
module decimal_digit_square_root
	import dds_pkg::*;
#(
	parameter int FRACTION_DIGITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [RADICAND_W-1:0] radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     scaled_root,
	output logic                  out_of_range
);

	localparam int NS = INT_PAIRS + FRACTION_DIGITS;

	logic                    v_s   [0:NS];
	logic                    oor_s [0:NS];
	pair_t [INT_PAIRS-1:0]   pr_s  [0:NS];
	rem_t                    rem_s [0:NS];
	root_t                   q_s   [0:NS];

	logic                     hi_pair;
	logic [RADICAND_W-1:0]    low_part;
	logic [DIV100_PROD_W-1:0] div_prod;
	pair_t                    mid_pair;
	logic [RADICAND_W-1:0]    low_rem;

	assign busy = 1'b0;

	assign hi_pair  = (radicand >= RADICAND_W'(RADICAND_LIMIT));
	assign low_part = hi_pair ? radicand - RADICAND_W'(RADICAND_LIMIT) : radicand;
	assign div_prod = DIV100_PROD_W'(low_part) * DIV100_PROD_W'(DIV100_MUL);
	assign mid_pair = div_prod[DIV100_SHIFT+PAIR_W-1:DIV100_SHIFT];
	assign low_rem  = low_part - RADICAND_W'(mid_pair) * RADICAND_W'(PAIR_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		oor_s[0] <= (radicand > RADICAND_W'(RADICAND_LIMIT));
		pr_s[0][0] <= PAIR_W'(hi_pair);
		pr_s[0][1] <= mid_pair;
		pr_s[0][2] <= low_rem[PAIR_W-1:0];
		rem_s[0] <= '0;
		q_s[0]   <= '0;
	end

	for (genvar k = 0; k < NS; k++) begin : g_digit
		pair_t pair;
		step_t nxt;
		if (k < INT_PAIRS) begin : g_int
			assign pair = pr_s[k][k];
		end else begin : g_frac
			assign pair = '0;
		end
		assign nxt = digit_step(rem_s[k], q_s[k], pair);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			oor_s[k+1] <= oor_s[k];
			pr_s[k+1]  <= pr_s[k];
			rem_s[k+1] <= nxt.rem;
			q_s[k+1]   <= nxt.q;
		end
	end

	assign done         = v_s[NS];
	assign out_of_range = oor_s[NS];
	assign scaled_root  = oor_s[NS] ? '0 : q_s[NS];

endmodule

// ===== src/dds_chk.sv =====
// Port-level checker for decimal_digit_square_root, with its bind.
// Depends on dds_pkg.
module dds_chk
	import dds_pkg::*;
#(
	parameter int FRACTION_DIGITS = 15
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [ROOT_W-1:0] scaled_root,
	input logic              out_of_range
);

	localparam int LAT = INT_PAIRS + FRACTION_DIGITS + 1;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing after transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (scaled_root == '0))
		else $error("nonzero root on error");

endmodule

bind decimal_digit_square_root dds_chk #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_dds_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.scaled_root(scaled_root), .out_of_range(out_of_range)
);
